/* src/nnsm_pkg.sv */
`timescale 1ns / 1ps

package nnsm_pkg;

  // Field widths
  localparam int DIM_W  = 13;            // size register width
  localparam int CRD_W  = 12;            // pixel coordinate width
  localparam int MODE_W = 2;
  localparam int IDX_W  = 3;             // config register index width
  localparam int OFF_W  = DIM_W + 1;     // signed placement offset
  localparam int REL_W  = OFF_W + 1;     // signed coordinate minus offset
  localparam int PROD_W = 2 * DIM_W;     // size by size product
  localparam int STEP_W = $clog2(PROD_W);

  // Per-item pipeline: coordinate, relative, product, one stage per quotient bit
  localparam int NDIV     = DIM_W;
  localparam int PIPE_LAT = 3 + NDIV;

  // Register reset values
  localparam logic [DIM_W-1:0]  SRC_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]  SRC_HEIGHT_RST = 13'd480;
  localparam logic [DIM_W-1:0]  WIN_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]  WIN_HEIGHT_RST = 13'd480;

  typedef enum logic [IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_WIN_WIDTH  = 3'd2,
    CFG_WIN_HEIGHT = 3'd3,
    CFG_SCALE_MODE = 3'd4
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CENTER  = 2'd0,
    MODE_STRETCH = 2'd1,
    MODE_FIT     = 2'd2
  } scale_mode_t;

  localparam logic [MODE_W-1:0] SCALE_MODE_RST = MODE_CENTER;

  typedef enum logic [2:0] {
    ST_READY,
    ST_PROD,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } setup_state_t;

  // Placement of one axis: where the picture starts, its size on screen,
  // the source size and the window size.
  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [DIM_W-1:0] dsz;
    logic [DIM_W-1:0] ssz;
    logic [DIM_W-1:0] win;
  } axis_geom_t;

  typedef struct packed {
    axis_geom_t x;
    axis_geom_t y;
    logic       black;   // every pixel is background
    logic       scale;   // source coordinate comes through the divider
  } geom_t;

  typedef struct packed {
    logic [CRD_W-1:0] src_col;
    logic [CRD_W-1:0] src_row;
    logic             visible;
  } res_t;

endpackage

/* src/nnsm_in_if.sv */
`timescale 1ns / 1ps

interface nnsm_in_if;
  logic                     valid;
  logic                     ready;
  logic [nnsm_pkg::CRD_W-1:0] out_x;
  logic [nnsm_pkg::CRD_W-1:0] out_y;

  modport source (output valid, output out_x, output out_y, input ready);
  modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

/* src/nnsm_out_if.sv */
`timescale 1ns / 1ps

interface nnsm_out_if;
  logic                     valid;
  logic                     ready;
  logic [nnsm_pkg::CRD_W-1:0] src_col;
  logic [nnsm_pkg::CRD_W-1:0] src_row;
  logic                     visible;

  modport source (output valid, output src_col, output src_row, output visible, input ready);
  modport sink   (input valid, input src_col, input src_row, input visible, output ready);
endinterface

/* src/nnsm_setup.sv */
`timescale 1ns / 1ps

module nnsm_setup #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [nnsm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [nnsm_pkg::DIM_W-1:0]   cfg_data,
  output nnsm_pkg::geom_t              geom,
  output logic                         ready
);

  localparam int DIM_W  = nnsm_pkg::DIM_W;
  localparam int OFF_W  = nnsm_pkg::OFF_W;
  localparam int PROD_W = nnsm_pkg::PROD_W;
  localparam int STEP_W = nnsm_pkg::STEP_W;

  logic [DIM_W-1:0]           src_w_r, src_h_r, win_w_r, win_h_r;
  logic [nnsm_pkg::MODE_W-1:0] mode_r;
  nnsm_pkg::setup_state_t     state_r, state_nxt;

  logic [PROD_W-1:0] prod_a_r, prod_b_r;   // win_w*src_h, win_h*src_w
  logic              wide_r;               // window wider than the picture
  logic [PROD_W-1:0] num_r, quo_r;
  logic [DIM_W-1:0]  rem_r, div_r;
  logic [STEP_W-1:0] step_r;
  nnsm_pkg::geom_t   geom_r, geom_nxt;

  logic [DIM_W-1:0]  sw, sh, ww, wh;
  logic              wide_c;
  logic [DIM_W:0]    trial;
  logic              ge;
  logic [DIM_W-1:0]  fit;

  function automatic logic [DIM_W-1:0] sat(input logic [DIM_W-1:0] v);
    if (32'(v) > MAX_DIM) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  // (a - b) / 2 truncated toward zero
  function automatic logic [OFF_W-1:0] half_diff(input logic [DIM_W-1:0] a,
                                                 input logic [DIM_W-1:0] b);
    logic [OFF_W-1:0] d;
    d = {1'b0, a} - {1'b0, b};
    d = d + {{(OFF_W-1){1'b0}}, d[OFF_W-1]};
    return $signed(d) >>> 1;
  endfunction

  assign sw = sat(src_w_r);
  assign sh = sat(src_h_r);
  assign ww = sat(win_w_r);
  assign wh = sat(win_h_r);

  assign wide_c = prod_a_r > prod_b_r;
  assign trial  = {rem_r, num_r[PROD_W-1]};
  assign ge     = trial >= {1'b0, div_r};
  // the fitted size never exceeds the window, so it fits a size register
  assign fit    = quo_r[DIM_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= nnsm_pkg::SRC_WIDTH_RST;
      src_h_r <= nnsm_pkg::SRC_HEIGHT_RST;
      win_w_r <= nnsm_pkg::WIN_WIDTH_RST;
      win_h_r <= nnsm_pkg::WIN_HEIGHT_RST;
      mode_r  <= nnsm_pkg::SCALE_MODE_RST;
    end else if (cfg_we) begin
      case (nnsm_pkg::cfg_idx_t'(cfg_index))
        nnsm_pkg::CFG_SRC_WIDTH:  src_w_r <= cfg_data;
        nnsm_pkg::CFG_SRC_HEIGHT: src_h_r <= cfg_data;
        nnsm_pkg::CFG_WIN_WIDTH:  win_w_r <= cfg_data;
        nnsm_pkg::CFG_WIN_HEIGHT: win_h_r <= cfg_data;
        nnsm_pkg::CFG_SCALE_MODE: mode_r  <= cfg_data[nnsm_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nnsm_pkg::ST_PROD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state: any write restarts the geometry computation
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nnsm_pkg::ST_READY:  state_nxt = nnsm_pkg::ST_READY;
      nnsm_pkg::ST_PROD:   state_nxt = nnsm_pkg::ST_LOAD;
      nnsm_pkg::ST_LOAD:   state_nxt = nnsm_pkg::ST_DIV;
      nnsm_pkg::ST_DIV: begin
        if (step_r == STEP_W'(PROD_W - 1)) state_nxt = nnsm_pkg::ST_FINISH;
      end
      nnsm_pkg::ST_FINISH: state_nxt = nnsm_pkg::ST_READY;
      default:             state_nxt = nnsm_pkg::ST_PROD;
    endcase
    if (cfg_we) state_nxt = nnsm_pkg::ST_PROD;
  end

  always_comb begin
    ready = (state_r == nnsm_pkg::ST_READY);
  end

  // datapath: products, compare, restoring divide one bit per cycle
  always_ff @(posedge clk) begin
    case (state_r)
      nnsm_pkg::ST_PROD: begin
        prod_a_r <= PROD_W'(ww) * PROD_W'(sh);
        prod_b_r <= PROD_W'(wh) * PROD_W'(sw);
      end
      nnsm_pkg::ST_LOAD: begin
        wide_r <= wide_c;
        num_r  <= wide_c ? prod_b_r : prod_a_r;
        div_r  <= wide_c ? sh : sw;
        rem_r  <= '0;
        quo_r  <= '0;
        step_r <= '0;
      end
      nnsm_pkg::ST_DIV: begin
        rem_r  <= ge ? DIM_W'(trial - {1'b0, div_r}) : trial[DIM_W-1:0];
        num_r  <= {num_r[PROD_W-2:0], 1'b0};
        quo_r  <= {quo_r[PROD_W-2:0], ge};
        step_r <= step_r + STEP_W'(1);
      end
      nnsm_pkg::ST_FINISH: geom_r <= geom_nxt;
      default: ;
    endcase
  end

  always_comb begin
    geom_nxt       = '0;
    geom_nxt.x.ssz = sw;
    geom_nxt.y.ssz = sh;
    geom_nxt.x.win = ww;
    geom_nxt.y.win = wh;
    case (nnsm_pkg::scale_mode_t'(mode_r))
      nnsm_pkg::MODE_CENTER: begin
        geom_nxt.x.off = half_diff(ww, sw);
        geom_nxt.y.off = half_diff(wh, sh);
        geom_nxt.x.dsz = sw;
        geom_nxt.y.dsz = sh;
      end
      nnsm_pkg::MODE_STRETCH: begin
        geom_nxt.scale = 1'b1;
        geom_nxt.x.dsz = ww;
        geom_nxt.y.dsz = wh;
      end
      nnsm_pkg::MODE_FIT: begin
        geom_nxt.scale = 1'b1;
        if (wide_r) begin
          geom_nxt.x.dsz = fit;
          geom_nxt.y.dsz = wh;
          geom_nxt.x.off = OFF_W'((ww - fit) >> 1);
        end else begin
          geom_nxt.x.dsz = ww;
          geom_nxt.y.dsz = fit;
          geom_nxt.y.off = OFF_W'((wh - fit) >> 1);
        end
        if (fit == '0) geom_nxt.black = 1'b1;
      end
      default: geom_nxt.black = 1'b1;
    endcase
    if (sw == '0 || sh == '0 || ww == '0 || wh == '0) geom_nxt.black = 1'b1;
  end

  assign geom = geom_r;

endmodule

/* src/nnsm_axis.sv */
`timescale 1ns / 1ps

module nnsm_axis (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [nnsm_pkg::CRD_W-1:0] coord,
  input  nnsm_pkg::axis_geom_t       geom,
  input  logic                       scale,
  output logic [nnsm_pkg::CRD_W-1:0] src,
  output logic                       in_rect
);

  localparam int DIM_W  = nnsm_pkg::DIM_W;
  localparam int CRD_W  = nnsm_pkg::CRD_W;
  localparam int OFF_W  = nnsm_pkg::OFF_W;
  localparam int REL_W  = nnsm_pkg::REL_W;
  localparam int PROD_W = nnsm_pkg::PROD_W;
  localparam int NDIV   = nnsm_pkg::NDIV;

  logic [CRD_W-1:0]  coord_r;
  logic [DIM_W-1:0]  rel_r;
  logic              in_r;
  logic [REL_W-1:0]  rel_s;
  logic              in_s;
  logic [PROD_W-1:0] prod;

  // divider stages: index 0 holds the split product
  logic [DIM_W-1:0] rem_q [NDIV+1];
  logic [DIM_W-1:0] num_q [NDIV+1];
  logic [DIM_W-1:0] quo_q [NDIV+1];
  logic [DIM_W-1:0] relq_q [NDIV+1];
  logic             in_q  [NDIV+1];

  logic [DIM_W-1:0] smax, q, res;

  assign rel_s = REL_W'($signed({{(REL_W-CRD_W){1'b0}}, coord_r})
                 - $signed({geom.off[OFF_W-1], geom.off}));
  assign in_s  = !rel_s[REL_W-1]
                 && (rel_s[REL_W-2:0] < (REL_W-1)'(geom.dsz))
                 && ({1'b0, coord_r} < geom.win);
  // rel < dsz keeps the product below dsz << DIM_W, so the upper half is a
  // valid starting remainder
  assign prod  = PROD_W'(rel_r) * PROD_W'(geom.ssz);

  always_ff @(posedge clk) begin
    if (adv) begin
      coord_r   <= coord;
      rel_r     <= rel_s[DIM_W-1:0];
      in_r      <= in_s;
      rem_q[0]  <= prod[PROD_W-1:DIM_W];
      num_q[0]  <= prod[DIM_W-1:0];
      quo_q[0]  <= '0;
      relq_q[0] <= rel_r;
      in_q[0]   <= in_r;
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [DIM_W:0] trial;
    logic           ge;

    assign trial = {rem_q[k], num_q[k][DIM_W-1]};
    assign ge    = trial >= {1'b0, geom.dsz};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k+1]  <= ge ? DIM_W'(trial - {1'b0, geom.dsz}) : trial[DIM_W-1:0];
        num_q[k+1]  <= {num_q[k][DIM_W-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][DIM_W-2:0], ge};
        relq_q[k+1] <= relq_q[k];
        in_q[k+1]   <= in_q[k];
      end
    end
  end

  assign smax = geom.ssz - DIM_W'(1);
  assign q    = quo_q[NDIV];
  assign res  = scale ? ((q > smax) ? smax : q) : relq_q[NDIV];

  assign src     = res[CRD_W-1:0];
  assign in_rect = in_q[NDIV];

endmodule

/* src/nnsm_outbuf.sv */
`timescale 1ns / 1ps

module nnsm_outbuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  nnsm_pkg::res_t  push_data,
  output logic            full,
  output logic            out_valid,
  input  logic            out_ready,
  output nnsm_pkg::res_t  out_data
);

  logic           main_v_r, skid_v_r;
  nnsm_pkg::res_t main_r, skid_r;
  logic           pop;

  assign pop = main_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        // no push can arrive while the skid entry is held
        if (pop) begin
          main_v_r <= 1'b1;
          skid_v_r <= 1'b0;
        end
      end else if (push) begin
        if (!main_v_r || pop) begin
          main_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (pop) begin
        main_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) main_r <= skid_r;
    end else if (push) begin
      if (!main_v_r || pop) main_r <= push_data;
      else                  skid_r <= push_data;
    end
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

/* src/nearest_neighbor_scale_mapper_top.sv */
`timescale 1ns / 1ps

// Maps a window pixel (out_x, out_y) to the source pixel to fetch, or marks it
// as black background, in centered, stretch or aspect-fit letterbox mode. Each
// result passes 16 pipeline stages, 13 of them a one-bit-per-stage divider for
// rel * src_size / dest_size, then the output register. One coordinate is
// taken per clock unless the output buffer is full or the block computes the
// letterbox geometry, after reset and after the last configuration write, with
// a sequential divider while in_ch.ready is low. Configuration writes are only
// allowed while no item is in flight: a rule on the user, not enforced here.
module nearest_neighbor_scale_mapper_top #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  nnsm_in_if.sink                    in_ch,
  nnsm_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [nnsm_pkg::IDX_W-1:0] cfg_index,
  input  logic [nnsm_pkg::DIM_W-1:0] cfg_data
);

  localparam int LAT   = nnsm_pkg::PIPE_LAT;
  localparam int CRD_W = nnsm_pkg::CRD_W;

  nnsm_pkg::geom_t  geom;
  logic             setup_ready;
  logic             adv, full, in_xfer, push;
  logic [LAT-1:0]   vld_r;
  logic [CRD_W-1:0] col, row;
  logic             x_in, y_in;
  nnsm_pkg::res_t   res, out_data;

  nnsm_setup #(.MAX_DIM(MAX_DIM)) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .ready     (setup_ready)
  );

  // the whole pipeline moves together; the output buffer decouples out_ready
  assign adv          = !full;
  assign in_ch.ready  = adv && setup_ready;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_xfer};
    end
  end

  nnsm_axis u_axis_x (
    .clk     (clk),
    .adv     (adv),
    .coord   (in_ch.out_x),
    .geom    (geom.x),
    .scale   (geom.scale),
    .src     (col),
    .in_rect (x_in)
  );

  nnsm_axis u_axis_y (
    .clk     (clk),
    .adv     (adv),
    .coord   (in_ch.out_y),
    .geom    (geom.y),
    .scale   (geom.scale),
    .src     (row),
    .in_rect (y_in)
  );

  always_comb begin
    res.visible = x_in && y_in && !geom.black;
    res.src_col = res.visible ? col : '0;
    res.src_row = res.visible ? row : '0;
  end

  assign push = adv && vld_r[LAT-1];

  nnsm_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (full),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.src_col = out_data.src_col;
  assign out_ch.src_row = out_data.src_row;
  assign out_ch.visible = out_data.visible;

endmodule
